### sv/dfr_pkg.sv
`default_nettype none

package dfr_pkg;

	localparam int FIFO_DEPTH = 4;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT      = 3'd1;
	localparam logic [2:0] ST_BAD_COUNT  = 3'd2;
	localparam logic [2:0] ST_TRUNC_HDR  = 3'd3;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
	localparam logic [2:0] ST_TRUNC_DATA = 3'd5;
	localparam logic [2:0] ST_TOO_LONG   = 3'd6;

	localparam logic KIND_CELL = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic        has_cell;
		logic        has_end;
		logic [10:0] column_index;
		logic        is_null;
		logic [23:0] cell_offset;
		logic [23:0] cell_length;
		logic [2:0]  status;
		logic [23:0] byte_count;
	} bundle_t;

endpackage

`default_nettype wire

### sv/data_row_cell_deframer.sv
// Row payload deframer: takes one payload byte per clock on the input channel and
// returns cell descriptors and one end-of-message status per message on the output
// channel, one result beat per clock unless stalled. A byte is classified
// combinationally and its results go into a four-entry queue as one bundle; a byte
// that both closes a cell and ends the message takes two output beats, so the
// sustained input rate is one byte per clock except where the queue fills. The
// input stalls only while that queue is full. described_fields is written through
// the cfg port, which is always ready, and should only change between messages.
`default_nettype none

module data_row_cell_deframer #(
	parameter int MAX_COLUMNS = 2048,
	parameter int OFFSET_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             record_kind,
	output logic [10:0]      column_index,
	output logic             is_null,
	output logic [23:0]      cell_offset,
	output logic [23:0]      cell_length,
	output logic [2:0]       status,
	output logic             last_result
);

	logic [11:0]      described_fields_q;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	dfr_pkg::bundle_t push_data;
	dfr_pkg::bundle_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			described_fields_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			described_fields_q <= cfg_data;
		end
	end

	dfr_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.described_fields (described_fields_q),
		.in_valid         (in_valid),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.full             (full),
		.in_stall         (in_stall),
		.push             (push),
		.push_data        (push_data)
	);

	dfr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head      (head)
	);

	dfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.record_kind  (record_kind),
		.column_index (column_index),
		.is_null      (is_null),
		.cell_offset  (cell_offset),
		.cell_length  (cell_length),
		.status       (status),
		.last_result  (last_result)
	);

endmodule

`default_nettype wire

### sv/dfr_front.sv
`default_nettype none

module dfr_front #(
	parameter int MAX_COLUMNS = 2048,
	parameter int OFFSET_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [11:0]      described_fields,
	input  wire logic             in_valid,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             full,
	output logic                  in_stall,
	output logic                  push,
	output dfr_pkg::bundle_t      push_data
);

	localparam int COL_W = $clog2(MAX_COLUMNS + 1);

	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_HDR   = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [1:0]             phase_q, nxt_phase;
	logic [OFFSET_BITS-1:0] pos_q, nxt_pos, pos_inc;
	logic [1:0]             seen_q, nxt_seen;
	logic [23:0]            shift_q, nxt_shift;
	logic [COL_W-1:0]       total_q, nxt_total;
	logic [COL_W-1:0]       col_q, nxt_col, col_inc;
	logic [30:0]            rem_q, nxt_rem;
	logic [23:0]            start_q, nxt_start;
	logic [23:0]            len_q, nxt_len;
	logic [2:0]             err_q, nxt_err;

	logic        accept;
	logic        cell_hit;
	logic        cell_null;
	logic [23:0] cell_off;
	logic [23:0] cell_len;
	logic        advance;
	logic [15:0] cnt;
	logic [31:0] hdr;
	logic [2:0]  end_status;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign pos_inc  = pos_q + 1'b1;
	assign col_inc  = col_q + 1'b1;
	assign cnt      = {shift_q[7:0], data_byte};
	assign hdr      = {shift_q, data_byte};

	always_comb begin
		nxt_phase = phase_q;
		nxt_pos   = pos_q;
		nxt_seen  = seen_q;
		nxt_shift = shift_q;
		nxt_total = total_q;
		nxt_col   = col_q;
		nxt_rem   = rem_q;
		nxt_start = start_q;
		nxt_len   = len_q;
		nxt_err   = err_q;
		cell_hit  = 1'b0;
		cell_null = 1'b0;
		cell_off  = '0;
		cell_len  = '0;
		advance   = 1'b0;
		if (err_q == dfr_pkg::ST_OK) begin
			if (pos_q == '1) begin
				nxt_err = dfr_pkg::ST_TOO_LONG;
			end else begin
				nxt_pos = pos_inc;
				case (phase_q)
					PH_COUNT: begin
						nxt_shift = {shift_q[15:0], data_byte};
						nxt_seen  = seen_q + 2'd1;
						if (seen_q == 2'd1) begin
							if (cnt[15] || (cnt > {4'd0, described_fields}) ||
							    (cnt > 16'(MAX_COLUMNS))) begin
								nxt_err = dfr_pkg::ST_BAD_COUNT;
							end else begin
								nxt_total = COL_W'(cnt);
								nxt_col   = '0;
								nxt_shift = '0;
								nxt_seen  = '0;
								nxt_phase = (cnt == 16'd0) ? PH_DONE : PH_HDR;
							end
						end
					end
					PH_HDR: begin
						nxt_shift = hdr[23:0];
						nxt_seen  = seen_q + 2'd1;
						if (seen_q == 2'd3) begin
							if (&hdr) begin
								cell_hit  = 1'b1;
								cell_null = 1'b1;
								cell_off  = 24'(pos_inc);
								advance   = 1'b1;
							end else if (hdr[31]) begin
								nxt_err = dfr_pkg::ST_BAD_LENGTH;
							end else if (hdr == 32'd0) begin
								cell_hit = 1'b1;
								cell_off = 24'(pos_inc);
								advance  = 1'b1;
							end else begin
								nxt_rem   = hdr[30:0];
								nxt_start = 24'(pos_inc);
								nxt_len   = hdr[23:0];
								nxt_phase = PH_DATA;
							end
						end
					end
					PH_DATA: begin
						nxt_rem = rem_q - 31'd1;
						if (rem_q == 31'd1) begin
							cell_hit = 1'b1;
							cell_off = start_q;
							cell_len = len_q;
							advance  = 1'b1;
						end
					end
					default: begin
					end
				endcase
				if (advance) begin
					nxt_col   = col_inc;
					nxt_shift = '0;
					nxt_seen  = '0;
					nxt_phase = (col_inc >= total_q) ? PH_DONE : PH_HDR;
				end
			end
		end
	end

	always_comb begin
		end_status = nxt_err;
		if (nxt_err == dfr_pkg::ST_OK) begin
			case (nxt_phase)
				PH_COUNT: end_status = dfr_pkg::ST_SHORT;
				PH_HDR:   end_status = dfr_pkg::ST_TRUNC_HDR;
				PH_DATA:  end_status = dfr_pkg::ST_TRUNC_DATA;
				default:  end_status = dfr_pkg::ST_OK;
			endcase
		end
	end

	assign push                   = accept && (cell_hit || last_byte);
	assign push_data.has_cell     = cell_hit;
	assign push_data.has_end      = last_byte;
	assign push_data.column_index = 11'(col_q);
	assign push_data.is_null      = cell_null;
	assign push_data.cell_offset  = cell_off;
	assign push_data.cell_length  = cell_len;
	assign push_data.status       = end_status;
	assign push_data.byte_count   = 24'(nxt_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			pos_q   <= '0;
			seen_q  <= '0;
			shift_q <= '0;
			total_q <= '0;
			col_q   <= '0;
			rem_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			err_q   <= dfr_pkg::ST_OK;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_COUNT;
				pos_q   <= '0;
				seen_q  <= '0;
				shift_q <= '0;
				total_q <= '0;
				col_q   <= '0;
				rem_q   <= '0;
				start_q <= '0;
				len_q   <= '0;
				err_q   <= dfr_pkg::ST_OK;
			end else begin
				phase_q <= nxt_phase;
				pos_q   <= nxt_pos;
				seen_q  <= nxt_seen;
				shift_q <= nxt_shift;
				total_q <= nxt_total;
				col_q   <= nxt_col;
				rem_q   <= nxt_rem;
				start_q <= nxt_start;
				len_q   <= nxt_len;
				err_q   <= nxt_err;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (err_q != dfr_pkg::ST_OK)) |-> !cell_hit)
		else $error("cell emitted after error");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (rem_q != 31'd0))
		else $error("data phase with nothing remaining");

endmodule

`default_nettype wire

### sv/dfr_fifo.sv
`default_nettype none

module dfr_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dfr_pkg::bundle_t  push_data,
	input  wire logic              pop,
	output logic                   full,
	output logic                   empty,
	output dfr_pkg::bundle_t       head
);

	localparam int AW = $clog2(dfr_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(dfr_pkg::FIFO_DEPTH + 1);

	dfr_pkg::bundle_t mem_q [dfr_pkg::FIFO_DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(dfr_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

### sv/dfr_back.sv
`default_nettype none

module dfr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire dfr_pkg::bundle_t  head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   record_kind,
	output logic [10:0]            column_index,
	output logic                   is_null,
	output logic [23:0]            cell_offset,
	output logic [23:0]            cell_length,
	output logic [2:0]             status,
	output logic                   last_result
);

	logic        valid_q;
	logic        half_q;
	logic        kind_q;
	logic [10:0] col_q;
	logic        null_q;
	logic [23:0] off_q;
	logic [23:0] len_q;
	logic [2:0]  status_q;
	logic        lastr_q;
	logic        load;
	logic        send_cell;

	assign load      = (!valid_q || !out_stall) && !empty;
	assign send_cell = head.has_cell && !half_q;
	assign pop       = load && !(send_cell && head.has_end);

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_cell) begin
				kind_q   <= dfr_pkg::KIND_CELL;
				col_q    <= head.column_index;
				null_q   <= head.is_null;
				off_q    <= head.cell_offset;
				len_q    <= head.cell_length;
				status_q <= dfr_pkg::ST_OK;
				lastr_q  <= !head.has_end;
			end else begin
				kind_q   <= dfr_pkg::KIND_END;
				col_q    <= '0;
				null_q   <= 1'b0;
				off_q    <= '0;
				len_q    <= head.byte_count;
				status_q <= head.status;
				lastr_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				half_q  <= send_cell && head.has_end;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_q;
	assign record_kind  = kind_q;
	assign column_index = col_q;
	assign is_null      = null_q;
	assign cell_offset  = off_q;
	assign cell_length  = len_q;
	assign status       = status_q;
	assign last_result  = lastr_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (!empty && head.has_cell && head.has_end))
		else $error("pending end status without its bundle");

endmodule

`default_nettype wire
